// ----- design/lqss_pkg.sv -----
// Shared types, constants and microcode program for the link quality score smoother.
// Used by link_quality_score_smoother_core; no other dependencies.
package lqss_pkg;

   // Width of a metric numerator once it is known to be below its span
   localparam int NUM_W = 14;

   // Normalization anchors, in input units
   localparam logic [NUM_W-1:0] TP_SPAN   = 14'd3200;
   localparam logic [NUM_W-1:0] RTT_TOP   = 14'd12800;
   localparam logic [NUM_W-1:0] RTT_SPAN  = 14'd12640;
   localparam logic [NUM_W-1:0] LOSS_TOP  = 14'd7680;
   localparam logic [NUM_W-1:0] LOSS_SPAN = 14'd7680;
   localparam logic [NUM_W-1:0] JIT_TOP   = 14'd3200;
   localparam logic [NUM_W-1:0] JIT_SPAN  = 14'd3200;

   // Metric slots
   localparam logic [1:0] M_TP   = 2'd0;
   localparam logic [1:0] M_RTT  = 2'd1;
   localparam logic [1:0] M_LOSS = 2'd2;
   localparam logic [1:0] M_JIT  = 2'd3;

   // CSR indexes
   localparam logic [2:0] CSR_WEIGHT_SET   = 3'd0;
   localparam logic [2:0] CSR_ALPHA        = 3'd1;
   localparam logic [2:0] CSR_PENALTY      = 3'd2;
   localparam logic [2:0] CSR_MIN_CONF     = 3'd3;
   localparam logic [2:0] CSR_CONF_CAP     = 3'd4;
   localparam logic [2:0] CSR_MODE         = 3'd5;

   localparam logic [63:0] WEIGHT_SET_RST = 64'h2000_2000_2000_2000;

   // Multiplier operand selects
   localparam logic [2:0] MOP_NONE  = 3'd0;
   localparam logic [2:0] MOP_EST   = 3'd1;  // numerator * reciprocal
   localparam logic [2:0] MOP_CHK   = 3'd2;  // estimated quotient * span
   localparam logic [2:0] MOP_WGT   = 3'd3;  // weight * normalized value
   localparam logic [2:0] MOP_ALPHA = 3'd4;  // alpha * raw
   localparam logic [2:0] MOP_BETA  = 3'd5;  // (1 - alpha) * previous

   // Accumulator ops
   localparam logic [1:0] AOP_HOLD  = 2'd0;
   localparam logic [1:0] AOP_CLEAR = 2'd1;
   localparam logic [1:0] AOP_ADD   = 2'd2;

   localparam int PC_W = 5;
   localparam logic [PC_W-1:0] UC_LAST_STEP = 5'd21;

   typedef struct packed {
      logic              sat;
      logic [NUM_W-1:0]  num;
   } metric_prep_type;

   typedef struct packed {
      logic [2:0]       mop;
      logic [1:0]       msel;
      logic [1:0]       aop;
      logic             fix_en;
      logic             raw_en;
      logic             skip_en;   // jump when no averaging is needed
      logic [PC_W-1:0]  target;
      logic             fin;
   } ucode_type;

   // Falling map: x at or above top gives zero, span or more below top saturates
   function automatic metric_prep_type prep_falling(input logic [15:0] x,
                                                    input logic [NUM_W-1:0] top,
                                                    input logic [NUM_W-1:0] span);
      metric_prep_type p;
      logic [15:0]     d;
      d = 16'(top) - x;
      p.sat = 1'b0;
      p.num = '0;
      if (x < 16'(top)) begin
         p.sat = d >= 16'(span);
         p.num = d[NUM_W-1:0];
      end
      return p;
   endfunction

   function automatic metric_prep_type prep_rising(input logic [15:0] x,
                                                   input logic [NUM_W-1:0] span);
      metric_prep_type p;
      p.sat = x >= 16'(span);
      p.num = x[NUM_W-1:0];
      return p;
   endfunction

   function automatic logic [NUM_W-1:0] span_of(input logic [1:0] m);
      logic [NUM_W-1:0] s;
      case (m)
         M_TP:    s = TP_SPAN;
         M_RTT:   s = RTT_SPAN;
         M_LOSS:  s = LOSS_SPAN;
         M_JIT:   s = JIT_SPAN;
         default: s = TP_SPAN;
      endcase
      return s;
   endfunction

   function automatic ucode_type uc_word(input logic [2:0] mop, input logic [1:0] msel,
                                         input logic [1:0] aop, input logic fix_en,
                                         input logic raw_en, input logic skip_en,
                                         input logic fin);
      ucode_type w;
      w.mop     = mop;
      w.msel    = msel;
      w.aop     = aop;
      w.fix_en  = fix_en;
      w.raw_en  = raw_en;
      w.skip_en = skip_en;
      w.target  = UC_LAST_STEP;
      w.fin     = fin;
      return w;
   endfunction

   // Program: per metric estimate, check, fix, weight; then raw, average, finish.
   // The accumulate of each weighted product rides on the next step.
   function automatic ucode_type ucode_rom(input logic [PC_W-1:0] pc);
      ucode_type w;
      case (pc)
         5'd0:    w = uc_word(MOP_EST,   M_TP,   AOP_CLEAR, 1'b0, 1'b0, 1'b0, 1'b0);
         5'd1:    w = uc_word(MOP_CHK,   M_TP,   AOP_HOLD,  1'b0, 1'b0, 1'b0, 1'b0);
         5'd2:    w = uc_word(MOP_NONE,  M_TP,   AOP_HOLD,  1'b1, 1'b0, 1'b0, 1'b0);
         5'd3:    w = uc_word(MOP_WGT,   M_TP,   AOP_HOLD,  1'b0, 1'b0, 1'b0, 1'b0);
         5'd4:    w = uc_word(MOP_EST,   M_RTT,  AOP_ADD,   1'b0, 1'b0, 1'b0, 1'b0);
         5'd5:    w = uc_word(MOP_CHK,   M_RTT,  AOP_HOLD,  1'b0, 1'b0, 1'b0, 1'b0);
         5'd6:    w = uc_word(MOP_NONE,  M_RTT,  AOP_HOLD,  1'b1, 1'b0, 1'b0, 1'b0);
         5'd7:    w = uc_word(MOP_WGT,   M_RTT,  AOP_HOLD,  1'b0, 1'b0, 1'b0, 1'b0);
         5'd8:    w = uc_word(MOP_EST,   M_LOSS, AOP_ADD,   1'b0, 1'b0, 1'b0, 1'b0);
         5'd9:    w = uc_word(MOP_CHK,   M_LOSS, AOP_HOLD,  1'b0, 1'b0, 1'b0, 1'b0);
         5'd10:   w = uc_word(MOP_NONE,  M_LOSS, AOP_HOLD,  1'b1, 1'b0, 1'b0, 1'b0);
         5'd11:   w = uc_word(MOP_WGT,   M_LOSS, AOP_HOLD,  1'b0, 1'b0, 1'b0, 1'b0);
         5'd12:   w = uc_word(MOP_EST,   M_JIT,  AOP_ADD,   1'b0, 1'b0, 1'b0, 1'b0);
         5'd13:   w = uc_word(MOP_CHK,   M_JIT,  AOP_HOLD,  1'b0, 1'b0, 1'b0, 1'b0);
         5'd14:   w = uc_word(MOP_NONE,  M_JIT,  AOP_HOLD,  1'b1, 1'b0, 1'b0, 1'b0);
         5'd15:   w = uc_word(MOP_WGT,   M_JIT,  AOP_HOLD,  1'b0, 1'b0, 1'b0, 1'b0);
         5'd16:   w = uc_word(MOP_NONE,  M_TP,   AOP_ADD,   1'b0, 1'b0, 1'b0, 1'b0);
         5'd17:   w = uc_word(MOP_NONE,  M_TP,   AOP_HOLD,  1'b0, 1'b1, 1'b1, 1'b0);
         5'd18:   w = uc_word(MOP_ALPHA, M_TP,   AOP_CLEAR, 1'b0, 1'b0, 1'b0, 1'b0);
         5'd19:   w = uc_word(MOP_BETA,  M_TP,   AOP_ADD,   1'b0, 1'b0, 1'b0, 1'b0);
         5'd20:   w = uc_word(MOP_NONE,  M_TP,   AOP_ADD,   1'b0, 1'b0, 1'b0, 1'b0);
         5'd21:   w = uc_word(MOP_NONE,  M_TP,   AOP_HOLD,  1'b0, 1'b0, 1'b0, 1'b1);
         default: w = uc_word(MOP_NONE,  M_TP,   AOP_HOLD,  1'b0, 1'b0, 1'b0, 1'b1);
      endcase
      return w;
   endfunction

endpackage

// ----- design/link_quality_score_smoother_core.sv -----
// Link quality score smoother: microcoded datapath with one shared multiplier.
// Requests are refused (req_stall) while a program run is busy. The program
// steps one control word per cycle through the single multiplier, except that
// the finish step waits while an earlier response is still stalled. Averaging
// is skipped on the first request, or when smoothing is off.
// Reset (synchronous): sequencer idle, CSRs to defaults, average unseeded and zero.
module link_quality_score_smoother_core
   import lqss_pkg::*;
#(
   parameter int SCORE_FRAC_BITS = 16
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [15:0] req_mean_throughput,
   input  logic [15:0] req_mean_rtt,
   input  logic [14:0] req_mean_loss,
   input  logic [15:0] req_mean_jitter,
   input  logic [16:0] req_confidence_level,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [16:0] rsp_raw_score,
   output logic [16:0] rsp_smoothed_out,
   output logic [16:0] rsp_used_score,
   output logic        rsp_low_confidence,
   input  logic        csr_wr_en,
   input  logic [2:0]  csr_index,
   input  logic [63:0] csr_wr_data
);

   localparam int SW = (SCORE_FRAC_BITS + 1 > 17) ? SCORE_FRAC_BITS + 1 : 17;
   localparam int MA = (SCORE_FRAC_BITS + 3 > 17) ? SCORE_FRAC_BITS + 3 : 17;
   localparam int PW = MA + SW;
   localparam int AW = PW + 2;
   localparam int RW = NUM_W + SCORE_FRAC_BITS;
   localparam logic [SW-1:0] ONE_VAL = SW'(1) << SCORE_FRAC_BITS;

   // floor(2^(F+14)/span): quotient estimate is exact or one low for num < span
   localparam logic [MA-1:0] R_TP   = MA'((64'd1 << RW) / TP_SPAN);
   localparam logic [MA-1:0] R_RTT  = MA'((64'd1 << RW) / RTT_SPAN);
   localparam logic [MA-1:0] R_LOSS = MA'((64'd1 << RW) / LOSS_SPAN);
   localparam logic [MA-1:0] R_JIT  = MA'((64'd1 << RW) / JIT_SPAN);

   // CSRs
   logic [63:0] weight_set_ff;
   logic [16:0] alpha_ff, penalty_ff, min_conf_ff, cap_ff;
   logic [2:0]  mode_ff;

   // sequencer
   logic            busy_ff, busy_in;
   logic [PC_W-1:0] pc_ff, pc_in;
   ucode_type       uc;
   logic            hold, step_go, req_take, rsp_take, skip_cond;

   // datapath
   logic [NUM_W-1:0] num_ff [4];
   logic [3:0]       sat_ff;
   logic [16:0]      conf_ff;
   logic [PW-1:0]    prod_ff, prod_in;
   logic [AW-1:0]    acc_ff, acc_in;
   logic [SW-1:0]    q_ff, norm_ff, norm_in, raw_ff, raw_in;
   logic [SW-1:0]    smooth_ff, smooth_in;
   logic             seeded_ff;

   logic [MA-1:0]    mul_a, recip;
   logic [SW-1:0]    mul_b, q_est, alpha_sat;
   logic [NUM_W-1:0] span, num_sel;
   logic [RW-1:0]    rem;
   logic [AW-1:0]    raw_wide;
   logic [SW-1:0]    ema, pen, e_val, cap, cand;
   logic             conf_is_low;

   // output register
   logic        rsp_valid_ff, rsp_valid_in;
   logic [16:0] rsp_raw_ff, rsp_smooth_ff, rsp_used_ff;
   logic        rsp_low_ff;

   metric_prep_type prep_tp, prep_rtt, prep_loss, prep_jit;

   assign uc        = ucode_rom(pc_ff);
   assign hold      = busy_ff && uc.fin && rsp_valid_ff && rsp_stall;
   assign step_go   = busy_ff && !hold;
   assign req_stall = busy_ff;
   assign req_take  = req_valid && !busy_ff;
   assign rsp_take  = rsp_valid_ff && !rsp_stall;
   assign skip_cond = !seeded_ff || !mode_ff[0];

   assign prep_tp   = prep_rising(req_mean_throughput, TP_SPAN);
   assign prep_rtt  = prep_falling(req_mean_rtt, RTT_TOP, RTT_SPAN);
   assign prep_loss = prep_falling({1'b0, req_mean_loss}, LOSS_TOP, LOSS_SPAN);
   assign prep_jit  = prep_falling(req_mean_jitter, JIT_TOP, JIT_SPAN);

   // ---------------- CSRs ----------------
   always_ff @(posedge clock) begin
      if (reset) begin
         weight_set_ff <= WEIGHT_SET_RST;
         alpha_ff      <= 17'd16384;
         penalty_ff    <= 17'd0;
         min_conf_ff   <= 17'd32768;
         cap_ff        <= 17'd65536;
         mode_ff       <= 3'd1;
      end else if (csr_wr_en) begin
         case (csr_index)
            CSR_WEIGHT_SET:   weight_set_ff <= csr_wr_data;
            CSR_ALPHA:        alpha_ff      <= csr_wr_data[16:0];
            CSR_PENALTY:      penalty_ff    <= csr_wr_data[16:0];
            CSR_MIN_CONF:     min_conf_ff   <= csr_wr_data[16:0];
            CSR_CONF_CAP:     cap_ff        <= csr_wr_data[16:0];
            CSR_MODE:         mode_ff       <= csr_wr_data[2:0];
            default: ;
         endcase
      end
   end

   // ---------------- sequencer ----------------
   always_comb begin
      busy_in = busy_ff;
      pc_in   = pc_ff;
      if (req_take) begin
         busy_in = 1'b1;
         pc_in   = '0;
      end else if (step_go) begin
         if (uc.fin) begin
            busy_in = 1'b0;
         end else if (uc.skip_en && skip_cond) begin
            pc_in = uc.target;
         end else begin
            pc_in = pc_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         pc_ff   <= '0;
      end else begin
         busy_ff <= busy_in;
         pc_ff   <= pc_in;
      end
   end

   // ---------------- shared multiplier ----------------
   assign alpha_sat = (SW'(alpha_ff) > ONE_VAL) ? ONE_VAL : SW'(alpha_ff);
   assign q_est     = prod_ff[NUM_W +: SW];
   assign span      = span_of(uc.msel);
   assign num_sel   = num_ff[uc.msel];

   always_comb begin
      case (uc.msel)
         M_TP:    recip = R_TP;
         M_RTT:   recip = R_RTT;
         M_LOSS:  recip = R_LOSS;
         M_JIT:   recip = R_JIT;
         default: recip = R_TP;
      endcase
   end

   always_comb begin
      mul_a = '0;
      mul_b = '0;
      case (uc.mop)
         MOP_EST: begin
            mul_a = recip;
            mul_b = SW'(num_sel);
         end
         MOP_CHK: begin
            mul_a = MA'(q_est);
            mul_b = SW'(span);
         end
         MOP_WGT: begin
            mul_a = MA'(weight_set_ff[16*uc.msel +: 16]);
            mul_b = norm_ff;
         end
         MOP_ALPHA: begin
            mul_a = MA'(alpha_sat);
            mul_b = raw_ff;
         end
         MOP_BETA: begin
            mul_a = MA'(ONE_VAL - alpha_sat);
            mul_b = smooth_ff;
         end
         default: ;
      endcase
      prod_in = {{SW{1'b0}}, mul_a} * {{MA{1'b0}}, mul_b};
   end

   // remainder of num*ONE - q_est*span lies in [0, 2*span)
   assign rem     = {num_sel, {SCORE_FRAC_BITS{1'b0}}} - prod_ff[RW-1:0];
   assign norm_in = sat_ff[uc.msel] ? ONE_VAL :
                    (rem >= RW'(span)) ? q_ff + 1'b1 : q_ff;

   always_comb begin
      case (uc.aop)
         AOP_CLEAR: acc_in = '0;
         AOP_ADD:   acc_in = acc_ff + AW'(prod_ff);
         default:   acc_in = acc_ff;
      endcase
   end

   assign raw_wide = acc_ff >> 15;
   assign raw_in   = (raw_wide > AW'(ONE_VAL)) ? ONE_VAL : raw_wide[SW-1:0];

   // ---------------- finish: penalty, seed, cap ----------------
   always_comb begin
      ema   = acc_ff[SCORE_FRAC_BITS +: SW];
      pen   = SW'(penalty_ff);
      cap   = SW'(cap_ff);
      e_val = ema;
      if (mode_ff[1] && raw_ff < smooth_ff) begin
         e_val = (ema > pen) ? ema - pen : '0;
      end
      if (e_val > ONE_VAL) begin
         e_val = ONE_VAL;
      end
      smooth_in   = skip_cond ? raw_ff : e_val;
      cand        = mode_ff[0] ? smooth_in : raw_ff;
      conf_is_low = conf_ff < min_conf_ff;
      if (mode_ff[2] && conf_is_low && cand > cap) begin
         cand = cap;
      end
   end

   // ---------------- datapath registers ----------------
   always_ff @(posedge clock) begin
      if (req_take) begin
         num_ff[M_TP]   <= prep_tp.num;
         num_ff[M_RTT]  <= prep_rtt.num;
         num_ff[M_LOSS] <= prep_loss.num;
         num_ff[M_JIT]  <= prep_jit.num;
         sat_ff         <= {prep_jit.sat, prep_loss.sat, prep_rtt.sat, prep_tp.sat};
         conf_ff        <= req_confidence_level;
      end
      if (step_go) begin
         if (uc.mop != MOP_NONE) begin
            prod_ff <= prod_in;
         end
         if (uc.mop == MOP_CHK) begin
            q_ff <= q_est;
         end
         if (uc.fix_en) begin
            norm_ff <= norm_in;
         end
         if (uc.raw_en) begin
            raw_ff <= raw_in;
         end
         acc_ff <= acc_in;
      end
      if (step_go && uc.fin) begin
         rsp_raw_ff    <= raw_ff[16:0];
         rsp_smooth_ff <= smooth_in[16:0];
         rsp_used_ff   <= cand[16:0];
         rsp_low_ff    <= conf_is_low;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         seeded_ff <= 1'b0;
         smooth_ff <= '0;
      end else if (step_go && uc.fin) begin
         seeded_ff <= 1'b1;
         smooth_ff <= smooth_in;
      end
   end

   assign rsp_valid_in = (step_go && uc.fin) ? 1'b1 : (rsp_take ? 1'b0 : rsp_valid_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_raw_score      = rsp_raw_ff;
   assign rsp_smoothed_out   = rsp_smooth_ff;
   assign rsp_used_score     = rsp_used_ff;
   assign rsp_low_confidence = rsp_low_ff;

`ifndef SYNTHESIS
   // a taken request starts the program at step zero
   a_start: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> busy_ff && pc_ff == '0)
      else $error("request taken without starting the sequencer");

   // the running average never leaves 0..ONE
   a_smooth_range: assert property (@(posedge clock) disable iff (reset)
      smooth_ff <= ONE_VAL)
      else $error("smoothed score above one");

   // a result only appears at the end of a program run
   a_rsp_from_fin: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(busy_ff) && $past(uc.fin))
      else $error("response raised outside the finish step");

   // a pending response is never overwritten while stalled
   a_no_overrun: assert property (@(posedge clock) disable iff (reset)
      busy_ff && uc.fin && rsp_valid_ff && rsp_stall |=> busy_ff && $stable(pc_ff))
      else $error("finish step advanced over a stalled response");

   // the program counter stays inside the program
   a_pc_range: assert property (@(posedge clock) disable iff (reset)
      busy_ff |-> pc_ff <= UC_LAST_STEP)
      else $error("program counter out of range");
`endif

endmodule
